// ----- rtl/core/tns_pkg.sv -----
// Package for the tone note sequencer: item types, state record, codes and note ROM tables.
package tns_pkg;

    localparam int MUSIC_TRACKS = 10;
    localparam int BURST_FRAMES = 15;
    localparam int BURST_W      = $clog2(BURST_FRAMES + 1);

    localparam int ROM_TRACKS   = 10;
    localparam int ROM_EFFECTS  = 7;
    localparam int MUSIC_SLOTS  = 14;
    localparam int EFFECT_SLOTS = 6;
    localparam int MAX_WRITES   = 3;

    // commands
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_MUSIC  = 2'd1;
    localparam logic [1:0] CMD_EFFECT = 2'd2;
    localparam logic [1:0] CMD_STOP   = 2'd3;

    // chip write kinds
    localparam logic [1:0] KIND_TONE  = 2'd0;
    localparam logic [1:0] KIND_ATT   = 2'd1;
    localparam logic [1:0] KIND_NOISE = 2'd2;

    // chip channels
    localparam logic [1:0] CH_MUSIC  = 2'd0;
    localparam logic [1:0] CH_EFFECT = 2'd1;
    localparam logic [1:0] CH_NOISE  = 2'd3;

    localparam logic [2:0]  EFFECT_NOISE_ID = 3'd7;
    localparam logic [10:0] ATT_ON          = 11'd4;
    localparam logic [10:0] ATT_OFF         = 11'd15;
    localparam logic [10:0] NOISE_WHITE     = 11'd0;
    localparam logic [7:0]  EFFECT_IDLE     = 8'hFF;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] music_id;
        logic [2:0] effect_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  write_kind;
        logic [1:0]  channel;
        logic [10:0] value;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]                  cnt;
        t_out_item [MAX_WRITES-1:0] slot;
    } t_wr_list;

    typedef struct packed {
        logic [3:0]         music_track;
        logic [3:0]         music_note_pos;
        logic [4:0]         music_frame_count;
        logic [2:0]         effect_track;
        logic [7:0]         effect_note_pos;
        logic [2:0]         effect_frame_count;
        logic [BURST_W-1:0] burst_frames_left;
    } t_state;

    localparam t_state STATE_RESET = '{
        music_track:        4'd0,
        music_note_pos:     4'd0,
        music_frame_count:  5'd0,
        effect_track:       3'd0,
        effect_note_pos:    EFFECT_IDLE,
        effect_frame_count: 3'd0,
        burst_frames_left:  '0
    };

    localparam logic [10:0] MUSIC_NOTES [ROM_TRACKS][MUSIC_SLOTS] = '{
        '{262, 294, 330, 349, 392, 440, 494, 523, 494, 440, 392, 349, 330, 294},
        '{262, 330, 392, 523, 392, 330, 294, 349, 440, 587, 440, 349, 0, 0},
        '{165, 175, 196, 233, 262, 233, 196, 175, 0, 0, 0, 0, 0, 0},
        '{262, 262, 311, 262, 196, 196, 233, 196, 0, 0, 0, 0, 0, 0},
        '{220, 262, 220, 330, 220, 262, 294, 262, 0, 0, 0, 0, 0, 0},
        '{262, 330, 392, 523, 587, 523, 392, 330, 349, 440, 523, 440, 0, 0},
        '{165, 165, 196, 165, 175, 175, 208, 175, 0, 0, 0, 0, 0, 0},
        '{262, 311, 370, 440, 370, 311, 0, 0, 0, 0, 0, 0, 0, 0},
        '{165, 247, 330, 247, 175, 262, 349, 262, 196, 294, 392, 294, 0, 0},
        '{392, 349, 330, 294, 262, 294, 330, 262, 0, 0, 0, 0, 0, 0}
    };
    localparam logic [3:0] MUSIC_COUNT  [ROM_TRACKS] = '{14, 12, 8, 8, 8, 12, 8, 6, 12, 8};
    localparam logic [4:0] MUSIC_FRAMES [ROM_TRACKS] = '{12, 10, 16, 7, 9, 8, 6, 6, 6, 14};

    localparam logic [10:0] EFFECT_NOTES [ROM_EFFECTS][EFFECT_SLOTS] = '{
        '{880, 660, 0, 0, 0, 0},
        '{440, 220, 0, 0, 0, 0},
        '{523, 659, 880, 0, 0, 0},
        '{880, 660, 440, 220, 0, 0},
        '{523, 659, 784, 1047, 0, 0},
        '{523, 587, 659, 784, 1047, 0},
        '{784, 659, 523, 440, 349, 262}
    };
    localparam logic [2:0] EFFECT_COUNT  [ROM_EFFECTS] = '{2, 2, 3, 4, 4, 5, 6};
    localparam logic [2:0] EFFECT_FRAMES [ROM_EFFECTS] = '{3, 5, 4, 5, 5, 6, 7};

    function automatic t_out_item mk_wr(input logic [1:0] kind, input logic [1:0] ch,
                                        input logic [10:0] val);
        t_out_item w;
        w.write_kind = kind;
        w.channel    = ch;
        w.value      = val;
        w.last       = 1'b0;
        return w;
    endfunction

endpackage

// ----- rtl/core/tns_state_mem.sv -----
// One-entry state memory with registered read, write forwarding and a reset-valid bit.
module tns_state_mem
    import tns_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_rd_en,
    input  logic   i_wr_en,
    input  t_state i_wr_data,
    output t_state o_rd_data
);

    t_state r_mem [1];
    logic   r_vld;
    t_state r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_wr_en) begin
            r_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[0] <= i_wr_data;
        end
    end

    // forward a write landing on the same edge as the read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en) begin
                r_rd_data <= i_wr_data;
            end else if (r_vld) begin
                r_rd_data <= r_mem[0];
            end else begin
                r_rd_data <= STATE_RESET;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/tns_step.sv -----
// Next-state and chip-write list for one command, from the state read out of memory.
module tns_step
    import tns_pkg::*;
(
    input  t_state   i_state,
    input  t_in_item i_item,
    output t_state   o_state,
    output t_wr_list o_list
);

    always_comb begin
        t_state                     s;
        t_wr_list                   lst;
        t_out_item [MAX_WRITES-1:0] cand;
        logic [MAX_WRITES-1:0]      hit;
        logic [3:0]                 mtrk;
        logic [4:0]                 mfc;
        logic [3:0]                 mpos;
        logic [2:0]                 etrk;
        logic [2:0]                 efc;
        logic [7:0]                 mid;

        s    = i_state;
        lst  = '0;
        cand = '0;
        hit  = '0;
        mtrk = (i_state.music_track < ROM_TRACKS) ? i_state.music_track : 4'd0;
        mfc  = i_state.music_frame_count + 5'd1;
        mpos = i_state.music_note_pos + 4'd1;
        etrk = i_state.effect_track;
        efc  = i_state.effect_frame_count + 3'd1;
        mid  = i_item.music_id;

        case (i_item.command)
            CMD_TICK: begin
                if (mfc >= MUSIC_FRAMES[mtrk]) begin
                    s.music_frame_count = '0;
                    if (mpos >= MUSIC_COUNT[mtrk]) begin
                        mpos = '0;
                    end
                    s.music_note_pos = mpos;
                    hit[0]  = 1'b1;
                    cand[0] = mk_wr(KIND_TONE, CH_MUSIC, MUSIC_NOTES[mtrk][mpos]);
                end else begin
                    s.music_frame_count = mfc;
                end

                if (etrk != EFFECT_NOISE_ID &&
                    i_state.effect_note_pos <= {5'd0, EFFECT_COUNT[etrk]}) begin
                    if (efc >= EFFECT_FRAMES[etrk]) begin
                        s.effect_frame_count = '0;
                        hit[1] = 1'b1;
                        if (i_state.effect_note_pos < {5'd0, EFFECT_COUNT[etrk]}) begin
                            cand[1] = mk_wr(KIND_TONE, CH_EFFECT,
                                EFFECT_NOTES[etrk][i_state.effect_note_pos[2:0]]);
                        end else begin
                            cand[1] = mk_wr(KIND_ATT, CH_EFFECT, ATT_OFF);
                        end
                        s.effect_note_pos = i_state.effect_note_pos + 8'd1;
                    end else begin
                        s.effect_frame_count = efc;
                    end
                end

                if (i_state.burst_frames_left != '0) begin
                    s.burst_frames_left = i_state.burst_frames_left - BURST_W'(1);
                    if (s.burst_frames_left == '0) begin
                        hit[2]  = 1'b1;
                        cand[2] = mk_wr(KIND_ATT, CH_NOISE, ATT_OFF);
                    end
                end

                // pack due writes in order: music, effect, burst
                for (int i = 0; i < MAX_WRITES; i++) begin
                    if (hit[i]) begin
                        lst.slot[lst.cnt] = cand[i];
                        lst.cnt = lst.cnt + 2'd1;
                    end
                end
            end
            CMD_MUSIC: begin
                if (mid >= MUSIC_TRACKS || mid >= ROM_TRACKS) begin
                    mid = '0;
                end
                s.music_track       = mid[3:0];
                s.music_note_pos    = '0;
                s.music_frame_count = '0;
                lst.cnt     = 2'd2;
                lst.slot[0] = mk_wr(KIND_ATT, CH_MUSIC, ATT_ON);
                lst.slot[1] = mk_wr(KIND_TONE, CH_MUSIC, MUSIC_NOTES[mid[3:0]][0]);
            end
            CMD_EFFECT: begin
                lst.cnt = 2'd2;
                if (i_item.effect_id == EFFECT_NOISE_ID) begin
                    lst.slot[0] = mk_wr(KIND_ATT, CH_NOISE, ATT_ON);
                    lst.slot[1] = mk_wr(KIND_NOISE, CH_NOISE, NOISE_WHITE);
                    s.burst_frames_left = BURST_W'(BURST_FRAMES);
                end else begin
                    s.effect_track       = i_item.effect_id;
                    s.effect_frame_count = '0;
                    s.effect_note_pos    = 8'd1;
                    lst.slot[0] = mk_wr(KIND_ATT, CH_EFFECT, ATT_ON);
                    lst.slot[1] = mk_wr(KIND_TONE, CH_EFFECT,
                        EFFECT_NOTES[i_item.effect_id][0]);
                end
            end
            default: begin
                lst.cnt     = 2'd3;
                lst.slot[0] = mk_wr(KIND_ATT, CH_MUSIC, ATT_OFF);
                lst.slot[1] = mk_wr(KIND_ATT, CH_EFFECT, ATT_OFF);
                lst.slot[2] = mk_wr(KIND_ATT, CH_NOISE, ATT_OFF);
                s.effect_note_pos   = EFFECT_IDLE;
                s.burst_frames_left = '0;
            end
        endcase

        if (lst.cnt != 2'd0) begin
            lst.slot[lst.cnt - 2'd1].last = 1'b1;
        end

        o_state = s;
        o_list  = lst;
    end

endmodule

// ----- rtl/core/tns_out_buf.sv -----
// Output buffer: holds one item's write list and hands out one write per cycle while not stalled.
module tns_out_buf
    import tns_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_wr_list  i_list,
    output logic      o_can_load,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic [1:0]                 r_cnt;
    logic [1:0]                 n_cnt;
    t_out_item [MAX_WRITES-1:0] r_slot;
    logic                       take;

    assign take       = (r_cnt != 2'd0) && !i_stall;
    // take a new list when empty or once the last held write leaves
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && take);

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_list.cnt;
        end else if (take) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_list.slot;
        end else if (take) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[0];

endmodule

// ----- rtl/core/tone_note_sequencer_core.sv -----
// Top level of the tone note sequencer: command intake, state memory, step logic, write output.
// Each command item is accepted into a read stage that fetches the sequencer state from a
// one-entry synchronous memory; once the output buffer can take a new list, the state is
// updated, written back and the resulting chip writes (0 to 3) are loaded into the output
// buffer. A write back on the same edge as the next read is forwarded, so items enter one per
// cycle while the output buffer keeps taking lists. The first write of an item is presented
// by the output buffer once its list is loaded; the output port delivers one write per cycle
// while not stalled, so an item yielding more than one write holds the path until all have
// left. Items yielding at most one write sustain one item per cycle. Reset needs no clearing pass.
module tone_note_sequencer_core
    import tns_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic     r_s1_vld;
    logic     n_s1_vld;
    t_in_item r_s1_item;
    logic     accept;
    logic     s1_go;
    logic     can_load;
    t_state   rd_state;
    t_state   wr_state;
    t_wr_list list;

    assign s1_go      = r_s1_vld && can_load;
    assign o_in_stall = r_s1_vld && !can_load;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_s1_vld   = accept || (r_s1_vld && !s1_go);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_in_item;
        end
    end

    tns_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_wr_en   (s1_go),
        .i_wr_data (wr_state),
        .o_rd_data (rd_state)
    );

    tns_step u_step (
        .i_state (rd_state),
        .i_item  (r_s1_item),
        .o_state (wr_state),
        .o_list  (list)
    );

    tns_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s1_go),
        .i_list     (list),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_item     (o_out_item)
    );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the tone note sequencer: command items in, chip writes checked.
`timescale 1ns / 100ps

module testbench;
    import tns_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 16;
    localparam int SETTLE_CYCLES = 20;
    localparam int NUM_TRACKS    = 10;
    localparam int FX_COUNT      = 7;

    localparam logic [10:0] TRACK_NOTE [NUM_TRACKS][14] = '{
        '{262, 294, 330, 349, 392, 440, 494, 523, 494, 440, 392, 349, 330, 294},
        '{262, 330, 392, 523, 392, 330, 294, 349, 440, 587, 440, 349, 0, 0},
        '{165, 175, 196, 233, 262, 233, 196, 175, 0, 0, 0, 0, 0, 0},
        '{262, 262, 311, 262, 196, 196, 233, 196, 0, 0, 0, 0, 0, 0},
        '{220, 262, 220, 330, 220, 262, 294, 262, 0, 0, 0, 0, 0, 0},
        '{262, 330, 392, 523, 587, 523, 392, 330, 349, 440, 523, 440, 0, 0},
        '{165, 165, 196, 165, 175, 175, 208, 175, 0, 0, 0, 0, 0, 0},
        '{262, 311, 370, 440, 370, 311, 0, 0, 0, 0, 0, 0, 0, 0},
        '{165, 247, 330, 247, 175, 262, 349, 262, 196, 294, 392, 294, 0, 0},
        '{392, 349, 330, 294, 262, 294, 330, 262, 0, 0, 0, 0, 0, 0}
    };
    localparam int TRACK_LEN    [NUM_TRACKS] = '{14, 12, 8, 8, 8, 12, 8, 6, 12, 8};
    localparam int TRACK_FRAMES [NUM_TRACKS] = '{12, 10, 16, 7, 9, 8, 6, 6, 6, 14};

    localparam logic [10:0] FX_NOTE [FX_COUNT][6] = '{
        '{880, 660, 0, 0, 0, 0},
        '{440, 220, 0, 0, 0, 0},
        '{523, 659, 880, 0, 0, 0},
        '{880, 660, 440, 220, 0, 0},
        '{523, 659, 784, 1047, 0, 0},
        '{523, 587, 659, 784, 1047, 0},
        '{784, 659, 523, 440, 349, 262}
    };
    localparam int FX_LEN    [FX_COUNT] = '{2, 2, 3, 4, 4, 5, 6};
    localparam int FX_FRAMES [FX_COUNT] = '{3, 5, 4, 5, 5, 6, 7};

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // sequencer state as the predictor sees it
    logic [3:0]         m_track    = 4'd0;
    logic [3:0]         m_pos      = 4'd0;
    logic [4:0]         m_frame    = 5'd0;
    logic [2:0]         fx_track   = 3'd0;
    logic [7:0]         fx_pos     = EFFECT_IDLE;
    logic [2:0]         fx_frame   = 3'd0;
    logic [BURST_W-1:0] burst_left = '0;

    t_out_item writes_due [$];
    int        errors     = 0;
    int        cycles     = 0;
    int        items_sent = 0;
    bit        idle_on    = 1'b1;

    always #4 i_clk = ~i_clk;

    tone_note_sequencer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_write(input logic [1:0] kind, input logic [1:0] ch,
                                      input logic [10:0] val);
        t_out_item w;
        w.write_kind = kind;
        w.channel    = ch;
        w.value      = val;
        w.last       = 1'b0;
        writes_due.push_back(w);
    endfunction

    // Advance the sequencer state by one command and queue the chip writes it causes.
    function automatic void predict_writes(input t_in_item it);
        int first;
        first = writes_due.size();
        case (it.command)
            CMD_TICK: begin
                m_frame = m_frame + 5'd1;
                if (m_frame >= TRACK_FRAMES[m_track]) begin
                    m_frame = '0;
                    m_pos   = 4'((m_pos + 1) % TRACK_LEN[m_track]);
                    add_write(KIND_TONE, CH_MUSIC, TRACK_NOTE[m_track][m_pos]);
                end
                if (fx_track < FX_COUNT && fx_pos <= FX_LEN[fx_track]) begin
                    fx_frame = fx_frame + 3'd1;
                    if (fx_frame >= FX_FRAMES[fx_track]) begin
                        fx_frame = '0;
                        if (fx_pos < FX_LEN[fx_track])
                            add_write(KIND_TONE, CH_EFFECT, FX_NOTE[fx_track][fx_pos[2:0]]);
                        else
                            add_write(KIND_ATT, CH_EFFECT, ATT_OFF);
                        fx_pos = fx_pos + 8'd1;
                    end
                end
                if (burst_left != 0) begin
                    burst_left = burst_left - BURST_W'(1);
                    if (burst_left == 0) add_write(KIND_ATT, CH_NOISE, ATT_OFF);
                end
            end
            CMD_MUSIC: begin
                m_track = (it.music_id >= MUSIC_TRACKS) ? 4'd0 : it.music_id[3:0];
                m_pos   = '0;
                m_frame = '0;
                add_write(KIND_ATT, CH_MUSIC, ATT_ON);
                add_write(KIND_TONE, CH_MUSIC, TRACK_NOTE[m_track][0]);
            end
            CMD_EFFECT: begin
                if (it.effect_id == EFFECT_NOISE_ID) begin
                    add_write(KIND_ATT, CH_NOISE, ATT_ON);
                    add_write(KIND_NOISE, CH_NOISE, NOISE_WHITE);
                    burst_left = BURST_W'(BURST_FRAMES);
                end else begin
                    fx_track = it.effect_id;
                    fx_frame = '0;
                    add_write(KIND_ATT, CH_EFFECT, ATT_ON);
                    add_write(KIND_TONE, CH_EFFECT, FX_NOTE[fx_track][0]);
                    fx_pos = 8'd1;
                end
            end
            default: begin
                add_write(KIND_ATT, CH_MUSIC, ATT_OFF);
                add_write(KIND_ATT, CH_EFFECT, ATT_OFF);
                add_write(KIND_ATT, CH_NOISE, ATT_OFF);
                fx_pos     = EFFECT_IDLE;
                burst_left = '0;
            end
        endcase
        if (writes_due.size() > first) writes_due[writes_due.size() - 1].last = 1'b1;
    endfunction

    // Present one command and hold it until the block takes it.
    task automatic issue_cmd(input logic [1:0] cmd, input logic [7:0] mid,
                             input logic [2:0] eid);
        int       gap;
        t_in_item it;
        it.command   = cmd;
        it.music_id  = mid;
        it.effect_id = eid;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predict_writes(it);
        items_sent++;
    endtask

    task automatic run_ticks(input int n);
        repeat (n) issue_cmd(CMD_TICK, 8'($urandom), 3'($urandom));
    endtask

    task automatic issue_random_cmd();
        issue_cmd(2'($urandom_range(0, 3)), 8'($urandom), 3'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (writes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        issue_cmd(CMD_TICK, 8'($urandom), 3'($urandom));      // nothing due after reset
        issue_cmd(CMD_MUSIC, 8'd0, 3'($urandom));
        issue_cmd(CMD_MUSIC, 8'd9, 3'($urandom));
        issue_cmd(CMD_MUSIC, 8'd10, 3'($urandom));    // out of range falls back to track 0
        issue_cmd(CMD_MUSIC, 8'hFF, 3'($urandom));
        for (int id = 0; id < 8; id++) issue_cmd(CMD_EFFECT, 8'($urandom), 3'(id));
        issue_cmd(CMD_STOP, 8'($urandom), 3'($urandom));
        run_ticks(3);
        issue_cmd(CMD_MUSIC, 8'd9, 3'd7);
        issue_cmd(CMD_EFFECT, 8'hFF, 3'd6);
        run_ticks(3);
        issue_cmd(CMD_STOP, 8'h00, 3'd0);
    endtask

    // Play the shortest and the longest effect through to the closing silence.
    task automatic test_effect_tail();
        issue_cmd(CMD_EFFECT, 8'($urandom), 3'd0);
        run_ticks(FX_LEN[0] * FX_FRAMES[0] + 2);
        issue_cmd(CMD_EFFECT, 8'($urandom), 3'd6);
        run_ticks(FX_LEN[6] * FX_FRAMES[6] + 2);
    endtask

    // Let one burst run out, then restart a burst before it ends.
    task automatic test_burst();
        issue_cmd(CMD_EFFECT, 8'($urandom), EFFECT_NOISE_ID);
        run_ticks(BURST_FRAMES + 2);
        issue_cmd(CMD_EFFECT, 8'($urandom), EFFECT_NOISE_ID);
        run_ticks(5);
        issue_cmd(CMD_EFFECT, 8'($urandom), EFFECT_NOISE_ID);
        run_ticks(BURST_FRAMES + 2);
    endtask

    // Music keeps stepping after stop; run past the end of the track to see it wrap.
    task automatic test_music_wrap();
        issue_cmd(CMD_MUSIC, 8'd7, 3'($urandom));
        run_ticks(20);
        issue_cmd(CMD_STOP, 8'($urandom), 3'($urandom));
        run_ticks(TRACK_LEN[7] * TRACK_FRAMES[7] - 20 + 8);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (20) issue_random_cmd();
        idle_on = 1'b1;
    endtask

    // Phrases: start music and effects, then a run of ticks, with stray commands mixed in.
    task automatic test_random_phrases();
        int stop_at;
        int r;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            idle_on = ($urandom_range(0, 4) != 0);
            r = $urandom_range(0, 99);
            if (r < 35)
                issue_cmd(CMD_MUSIC, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(10, 255))
                                                                  : 8'($urandom_range(0, 9)),
                          3'($urandom));
            else if (r < 75)
                issue_cmd(CMD_EFFECT, 8'($urandom), 3'($urandom));
            else if (r < 85)
                issue_cmd(CMD_STOP, 8'($urandom), 3'($urandom));
            if ($urandom_range(0, 3) == 0) issue_random_cmd();
            run_ticks($urandom_range(1, 12));
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        idle_on = 1'b1;
    endtask

    initial begin : out_stall_drive
        int hold;
        @(posedge i_clk);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    task automatic check_field(input string name, input logic [10:0] want,
                               input logic [10:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_writes
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (writes_due.size() == 0) begin
                $display("%0t: unexpected write: expected none, actual %0d/%0d/%0d/%0b",
                         $time, out_item.write_kind, out_item.channel, out_item.value,
                         out_item.last);
                errors++;
            end else begin
                want = writes_due.pop_front();
                check_field("write_kind", 11'(want.write_kind), 11'(out_item.write_kind));
                check_field("channel", 11'(want.channel), 11'(out_item.channel));
                check_field("value", want.value, out_item.value);
                check_field("last", 11'(want.last), 11'(out_item.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin : run_tests
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        wait_drained();
        test_effect_tail();
        wait_drained();
        test_burst();
        test_music_wrap();
        wait_drained();
        test_back_to_back();
        test_random_phrases();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tns_pkg.sv
rtl/core/tns_state_mem.sv
rtl/core/tns_step.sv
rtl/core/tns_out_buf.sv
rtl/core/tone_note_sequencer_core.sv
dv/testbench.sv
